// ===== design/mtp_pkg.sv =====
`default_nettype none

package mtp_pkg;

  // tag that opens every track chunk
  localparam logic [31:0] TAG_MTRK = 32'h4D54_726B;

  // meta type that closes a track
  localparam logic [7:0] META_END_OF_TRACK = 8'h2F;

  // status nibbles of the one-data-byte channel messages
  localparam logic [3:0] STAT_PROG_CHANGE = 4'hC;
  localparam logic [3:0] STAT_CHAN_PRESS  = 4'hD;

  // queue geometry
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_CW    = 3;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_HEADER    = 4'd1,
    PH_DELTA     = 4'd2,
    PH_STATUS    = 4'd3,
    PH_DATA1     = 4'd4,
    PH_DATA2     = 4'd5,
    PH_META_TYPE = 4'd6,
    PH_META_LEN  = 4'd7,
    PH_META_DATA = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    KIND_CHANNEL   = 3'd0,
    KIND_META_HDR  = 3'd1,
    KIND_META_BYTE = 3'd2,
    KIND_END       = 3'd3,
    KIND_ERROR     = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_TAG   = 3'd1,
    ERR_BAD_STAT  = 3'd2,
    ERR_LEN_DELTA = 3'd3,
    ERR_LEN_MISM  = 3'd4
  } err_t;

  // one result item, last field in the lowest bits
  typedef struct packed {
    logic [7:0]  meta_byte;
    logic [31:0] meta_length;
    logic [7:0]  meta_type;
    logic [7:0]  second_data;
    logic [7:0]  first_data;
    logic [3:0]  channel;
    logic [3:0]  status_high;
    logic [31:0] delta_time;
    err_t        error_code;
    kind_t       result_kind;
  } res_t;

  // a result item with its end-of-run mark
  typedef struct packed {
    logic last;
    res_t res;
  } entry_t;

  // results produced by one byte
  typedef struct packed {
    logic [1:0] count;
    entry_t     first;
    entry_t     second;
  } push_t;

endpackage

`default_nettype wire

// ===== design/midi_track_event_parser.sv =====
// path: a byte taken goes to the input register and, once the queue has room,
//   its results are written to the result queue, whose head is offered out
// throughput: one track byte per cycle; a byte giving two results offers them
//   one after the other on the output, and input stalls while the four-entry
//   result queue holds more than two entries
// reset: rst_n synchronous, active low; parser idle, queue empty, strict_mode 1
`default_nettype none

module midi_track_event_parser
  import mtp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // track_byte
  input  wire logic         in_tuser,   // start_of_track
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // result_kind, error_code, delta_time, status_high, channel, first_data,
  // second_data, meta_type, meta_length, meta_byte, two zero bits
  output logic [111:0]      out_tdata,
  output logic              out_tlast,  // last_in_run
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_wr_data  // strict_mode
);

  logic                byte_v_r;
  logic [7:0]          byte_r;
  logic                sot_r;
  logic                strict_r;
  logic                advance;
  push_t               push;
  entry_t              head;
  logic                q_valid;
  logic [QUEUE_CW-1:0] q_fill;

  // byte is consumed once the queue has room for two results
  assign advance   = byte_v_r && (q_fill <= QUEUE_CW'(QUEUE_DEPTH - 2));
  assign in_tready = !byte_v_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_v_r <= 1'b0;
    end else if (in_tready) begin
      byte_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
      sot_r  <= in_tuser;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b1;
    end else if (cfg_wr_en) begin
      strict_r <= cfg_wr_data;
    end
  end

  mtp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (advance),
    .byte_in     (byte_r),
    .sot_in      (sot_r),
    .strict_mode (strict_r),
    .push        (push)
  );

  mtp_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_tready),
    .not_empty (q_valid),
    .fill      (q_fill),
    .head      (head)
  );

  // result channel
  assign out_tvalid = q_valid;
  assign out_tdata  = {2'b00, head.res};
  assign out_tlast  = head.last;

endmodule

`default_nettype wire

// ===== design/mtp_parser.sv =====
`default_nettype none

module mtp_parser
  import mtp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_valid,
  input  wire logic [7:0] byte_in,
  input  wire logic       sot_in,
  input  wire logic       strict_mode,
  output push_t           push
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] hshift_r, hshift_nxt;
  logic [2:0]  hcount_r, hcount_nxt;
  logic [31:0] brem_r, brem_nxt;
  logic [7:0]  run_r, run_nxt;
  logic [31:0] dacc_r, dacc_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  mtype_r, mtype_nxt;
  logic [31:0] mlen_r, mlen_nxt;
  logic [31:0] mleft_r, mleft_nxt;

  logic [31:0] hshift_sh, brem_dec, dacc_new, mlen_new, mleft_dec;
  logic        take_d1, take_mt, fin;
  logic [31:0] fin_len;
  res_t        row0, row1;
  logic [1:0]  nres;

  function automatic res_t err_row(input err_t code);
    res_t r;
    r = '0;
    r.result_kind = KIND_ERROR;
    r.error_code  = code;
    return r;
  endfunction

  function automatic res_t ev_row(input kind_t k, input logic [31:0] dt,
                                  input logic [7:0] st);
    res_t r;
    r = '0;
    r.result_kind = k;
    r.delta_time  = dt;
    r.status_high = st[7:4];
    r.channel     = st[3:0];
    return r;
  endfunction

  // shared arithmetic
  assign hshift_sh = {hshift_r[23:0], byte_in};
  assign brem_dec  = brem_r - 32'd1;
  assign dacc_new  = {dacc_r[24:0], 7'd0} + {25'd0, byte_in[6:0]};
  assign mlen_new  = {mlen_r[24:0], 7'd0} + {25'd0, byte_in[6:0]};
  assign mleft_dec = mleft_r - 32'd1;

  // next state and results of one byte
  always_comb begin
    phase_nxt  = phase_r;
    hshift_nxt = hshift_r;
    hcount_nxt = hcount_r;
    brem_nxt   = brem_r;
    run_nxt    = run_r;
    dacc_nxt   = dacc_r;
    held_nxt   = held_r;
    mtype_nxt  = mtype_r;
    mlen_nxt   = mlen_r;
    mleft_nxt  = mleft_r;
    take_d1    = 1'b0;
    take_mt    = 1'b0;
    fin        = 1'b0;
    fin_len    = mlen_r;
    row0       = '0;
    row1       = '0;
    nres       = 2'd0;

    if (byte_valid && sot_in) begin
      phase_nxt  = PH_HEADER;
      hshift_nxt = {24'd0, byte_in};
      hcount_nxt = 3'd1;
      brem_nxt   = '0;
      run_nxt    = '0;
      dacc_nxt   = '0;
      held_nxt   = '0;
      mtype_nxt  = '0;
      mlen_nxt   = '0;
      mleft_nxt  = '0;
    end else if (byte_valid) begin
      case (phase_r)
        PH_HEADER: begin
          hshift_nxt = hshift_sh;
          if (hcount_r == 3'd3 && hshift_sh != TAG_MTRK) begin
            row0      = err_row(ERR_BAD_TAG);
            nres      = 2'd1;
            phase_nxt = PH_IDLE;
          end else if (hcount_r == 3'd7) begin
            hcount_nxt = 3'd0;
            brem_nxt   = hshift_sh;
            if (hshift_sh == 32'd0 && strict_mode) begin
              row0             = '0;
              row0.result_kind = KIND_END;
              nres             = 2'd1;
              phase_nxt        = PH_IDLE;
            end else begin
              dacc_nxt  = '0;
              phase_nxt = PH_DELTA;
            end
          end else begin
            hcount_nxt = hcount_r + 3'd1;
          end
        end
        PH_DELTA: begin
          dacc_nxt = dacc_new;
          brem_nxt = brem_dec;
          if (brem_dec == 32'd0) begin
            row0      = err_row(ERR_LEN_DELTA);
            nres      = 2'd1;
            phase_nxt = PH_IDLE;
          end else if (!byte_in[7]) begin
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (byte_in[7]) begin
            brem_nxt  = brem_dec;
            run_nxt   = byte_in;
            phase_nxt = (byte_in[7:4] == 4'hF) ? PH_META_TYPE : PH_DATA1;
          end else if (!run_r[7]) begin
            row0      = err_row(ERR_BAD_STAT);
            nres      = 2'd1;
            phase_nxt = PH_IDLE;
          end else if (run_r[7:4] == 4'hF) begin
            take_mt = 1'b1;
          end else begin
            take_d1 = 1'b1;
          end
        end
        PH_DATA1: begin
          take_d1 = 1'b1;
        end
        PH_DATA2: begin
          brem_nxt         = brem_dec;
          row0             = ev_row(KIND_CHANNEL, dacc_r, run_r);
          row0.first_data  = held_r;
          row0.second_data = byte_in;
          nres             = 2'd1;
          dacc_nxt         = '0;
          phase_nxt        = PH_DELTA;
        end
        PH_META_TYPE: begin
          take_mt = 1'b1;
        end
        PH_META_LEN: begin
          brem_nxt = brem_dec;
          mlen_nxt = mlen_new;
          if (!byte_in[7]) begin
            mleft_nxt        = mlen_new;
            row0             = ev_row(KIND_META_HDR, dacc_r, run_r);
            row0.meta_type   = mtype_r;
            row0.meta_length = mlen_new;
            nres             = 2'd1;
            fin_len          = mlen_new;
            if (mlen_new == 32'd0) begin
              fin = 1'b1;
            end else begin
              phase_nxt = PH_META_DATA;
            end
          end
        end
        PH_META_DATA: begin
          brem_nxt         = brem_dec;
          row0             = ev_row(KIND_META_BYTE, dacc_r, run_r);
          row0.meta_type   = mtype_r;
          row0.meta_length = mlen_r;
          row0.meta_byte   = byte_in;
          nres             = 2'd1;
          mleft_nxt        = mleft_dec;
          fin              = (mleft_dec == 32'd0);
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      // first data byte of a channel message
      if (take_d1) begin
        brem_nxt = brem_dec;
        if (run_r[7:4] == STAT_PROG_CHANGE || run_r[7:4] == STAT_CHAN_PRESS) begin
          row0            = ev_row(KIND_CHANNEL, dacc_r, run_r);
          row0.first_data = byte_in;
          nres            = 2'd1;
          dacc_nxt        = '0;
          phase_nxt       = PH_DELTA;
        end else begin
          held_nxt  = byte_in;
          phase_nxt = PH_DATA2;
        end
      end

      // meta type byte
      if (take_mt) begin
        brem_nxt  = brem_dec;
        mtype_nxt = byte_in;
        mlen_nxt  = '0;
        phase_nxt = PH_META_LEN;
      end

      // close of a meta event
      if (fin) begin
        if (mtype_r == META_END_OF_TRACK) begin
          phase_nxt = PH_IDLE;
          nres      = 2'd2;
          if (strict_mode && brem_dec != 32'd0) begin
            row1 = err_row(ERR_LEN_MISM);
          end else begin
            row1             = ev_row(KIND_END, dacc_r, run_r);
            row1.meta_type   = mtype_r;
            row1.meta_length = fin_len;
          end
        end else begin
          dacc_nxt  = '0;
          phase_nxt = PH_DELTA;
        end
      end
    end
  end

  // results to the queue
  always_comb begin
    push              = '0;
    push.count        = nres;
    push.first.res    = row0;
    push.first.last   = (nres == 2'd1);
    push.second.res   = row1;
    push.second.last  = 1'b1;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      hshift_r <= '0;
      hcount_r <= '0;
      brem_r   <= '0;
      run_r    <= '0;
      dacc_r   <= '0;
      held_r   <= '0;
      mtype_r  <= '0;
      mlen_r   <= '0;
      mleft_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      hshift_r <= hshift_nxt;
      hcount_r <= hcount_nxt;
      brem_r   <= brem_nxt;
      run_r    <= run_nxt;
      dacc_r   <= dacc_nxt;
      held_r   <= held_nxt;
      mtype_r  <= mtype_nxt;
      mlen_r   <= mlen_nxt;
      mleft_r  <= mleft_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/mtp_out_queue.sv =====
`default_nettype none

module mtp_out_queue
  import mtp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire push_t             push,
  input  wire logic              pop,
  output logic                   not_empty,
  output logic [QUEUE_CW-1:0]    fill,
  output entry_t                 head
);

  entry_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_r, wptr_nxt;
  logic [QUEUE_AW-1:0] rptr_r, rptr_nxt;
  logic [QUEUE_CW-1:0] cnt_r, cnt_nxt;
  logic [QUEUE_AW-1:0] wptr_inc;
  logic                do_pop;

  assign not_empty = (cnt_r != '0);
  assign fill      = cnt_r;
  assign head      = mem[rptr_r];
  assign do_pop    = pop && not_empty;
  assign wptr_inc  = wptr_r + {{(QUEUE_AW-1){1'b0}}, 1'b1};

  // pointer and fill bookkeeping
  always_comb begin
    wptr_nxt = wptr_r + push.count;
    rptr_nxt = rptr_r + {{(QUEUE_AW-1){1'b0}}, do_pop};
    cnt_nxt  = cnt_r + {{(QUEUE_CW-2){1'b0}}, push.count}
               - {{(QUEUE_CW-1){1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // entry storage, up to two writes a cycle
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wptr_inc] <= push.second;
    end
  end

endmodule

`default_nettype wire

// ===== design/mtp_checker.sv =====
`default_nettype none

module mtp_checker
  import mtp_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [111:0] out_tdata,
  input wire logic         out_tlast
);

  // nothing is offered right after a reset cycle
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // a stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // the rest of a run is already queued when its first part is taken
  a_run_whole: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("run split by a gap");

  // error results carry a code and nothing else of the event
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == KIND_ERROR |->
      out_tdata[5:3] != ERR_NONE && out_tdata[111:6] == '0)
    else $error("malformed error result");

  // non-error results carry no error code
  a_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != KIND_ERROR |-> out_tdata[5:3] == ERR_NONE)
    else $error("error code on a normal result");

endmodule

bind midi_track_event_parser mtp_checker u_mtp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
